/* rtl/rqk_pkg.sv */
// ----------------------------------------------------------------------------
// rqk_pkg
// shared codes, field widths and cell control type of the retroactive queue
// ----------------------------------------------------------------------------
package rqk_pkg;

  // field widths
  localparam int CMD_W       = 3;
  localparam int TIME_REQ_W  = 32;
  localparam int VALUE_W     = 32;
  localparam int RANK_W      = 7;
  localparam int STATUS_W    = 2;
  localparam int SIZE_W      = 7;

  // packed stream widths
  localparam int IN_DATA_W   = 72;  // time_req, entry_value, rank, pad
  localparam int OUT_DATA_W  = 40;  // result_value, live_size, pad

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD_ENQ = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DEQ = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_ENQ = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_DEQ = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ELEMENT  = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd127;

  // per-row update strobes broadcast to every cell
  typedef struct packed {
    logic ins;  // sorted insert of the key
    logic rem;  // remove last entry at or before the key
  } cell_ctl_t;

endpackage

/* rtl/rqk_cell.sv */
// ----------------------------------------------------------------------------
// rqk_cell
// one slot of a sorted row: holds a timestamp and a payload, shifts to or
// from its neighbors on insert and remove
// ----------------------------------------------------------------------------
module rqk_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32,
  parameter int VAL_BITS  = 32,
  parameter int WANT_W    = 8
) (
  input  logic                  clk,
  input  rqk_pkg::cell_ctl_t    ctl,
  input  logic                  valid,
  input  logic [TIME_BITS-1:0]  key,
  input  logic [VAL_BITS-1:0]   new_val,
  input  logic                  le_prev,
  input  logic                  le_next,
  input  logic [TIME_BITS-1:0]  prev_stamp,
  input  logic [VAL_BITS-1:0]   prev_val,
  input  logic [TIME_BITS-1:0]  next_stamp,
  input  logic [VAL_BITS-1:0]   next_val,
  input  logic [WANT_W-1:0]     want,
  output logic                  le,
  output logic                  exact,
  output logic [TIME_BITS-1:0]  stamp,
  output logic [VAL_BITS-1:0]   val,
  output logic [VAL_BITS-1:0]   sel_val
);
  import rqk_pkg::*;

  localparam logic [WANT_W-1:0] MY_RANK = WANT_W'(IDX + 1);

  assign le      = valid && (stamp <= key);
  // last entry at or before the key, with an exact time match
  assign exact   = le && !le_next && (stamp == key);
  assign sel_val = (want == MY_RANK) ? val : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      stamp <= le_prev ? key : prev_stamp;
      val   <= le_prev ? new_val : prev_val;
    end else if (ctl.rem && !le_next) begin
      stamp <= next_stamp;
      val   <= next_val;
    end
  end

endmodule

/* rtl/rqk_count.sv */
// ----------------------------------------------------------------------------
// rqk_count
// turns the thermometer of at-or-before flags of a sorted row into a count
// ----------------------------------------------------------------------------
module rqk_count #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7
) (
  input  logic [CAPACITY-1:0] le,
  output logic [CNT_W-1:0]    count
);
  import rqk_pkg::*;

  // one-hot boundary between the set prefix and the clear suffix
  logic [CAPACITY:0] edge_pos;

  always_comb begin
    edge_pos[0]        = !le[0];
    edge_pos[CAPACITY] = le[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      edge_pos[i] = le[i-1] && !le[i];
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (edge_pos[i]) begin
        count = count | CNT_W'(i);
      end
    end
  end

endmodule

/* rtl/retroactive_queue_kth_query.sv */
// ----------------------------------------------------------------------------
// retroactive_queue_kth_query
// totally retroactive fifo queue with k-th element query over past times
// ----------------------------------------------------------------------------
// usage
//   s_* channel carries one command per transaction: add or remove an enqueue
//   or a dequeue at any timestamp, or ask for the k-th queued element at a
//   time. m_* channel returns exactly one result transaction per command:
//   status, value and the live queue size at the command's time.
//   both tables are rows of CAPACITY cells kept sorted by time; every cell
//   compares its stamp with the key in parallel and shifts to or from its
//   neighbor, all cells of a row at once.
//   the command is registered, then evaluated in the compare/update step,
//   then the k-th select step loads the result into the output reg.
//   a new command is taken in the select step of the previous one if the
//   output register can take that result.
//   reset clears the state, both fill counts and the output valid flag;
//   cells need no clearing since only cells below the counts are ever looked at.
//   when m_tready is low the result holds in the output register; one more
//   command is taken and evaluated, then the block waits in its select step.
// ----------------------------------------------------------------------------
module retroactive_queue_kth_query #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // time_req[31:0], entry_value[63:32], rank[70:64], zero pad
  input  logic [rqk_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd[2:0]
  input  logic [rqk_pkg::CMD_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // result_value[31:0], live_size[38:32], zero pad
  output logic [rqk_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [rqk_pkg::STATUS_W-1:0]     m_tuser
);
  import rqk_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WANT_W = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;
  localparam int SZ_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_SEL  = 3'b100
  } state_t;

  state_t state, state_next;

  // command register
  logic [CMD_W-1:0]     cmd_q;
  logic [TIME_BITS-1:0] key_q;
  logic [VALUE_W-1:0]   val_q;
  logic [RANK_W-1:0]    rank_q;
  logic [63:0]          time_wide;

  // fill counts
  logic [CNT_W-1:0] enq_cnt, enq_cnt_next;
  logic [CNT_W-1:0] deq_cnt, deq_cnt_next;

  // evaluation results held for the select step
  logic [STATUS_W-1:0] st_status;
  logic [SIZE_W-1:0]   st_size;
  logic [WANT_W-1:0]   st_want;
  logic                st_qok;

  // output register
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [SIZE_W-1:0]   out_size;

  logic s_xfer, out_free;

  // cell rows
  cell_ctl_t            enq_ctl, deq_ctl;
  logic [CAPACITY-1:0]  enq_valid, enq_le, enq_exact;
  logic [CAPACITY-1:0]  deq_valid, deq_le, deq_exact;
  logic [TIME_BITS-1:0] enq_stamp [CAPACITY];
  logic [VALUE_W-1:0]   enq_val   [CAPACITY];
  logic [VALUE_W-1:0]   enq_sel   [CAPACITY];
  logic [TIME_BITS-1:0] deq_stamp [CAPACITY];
  logic [0:0]           deq_val   [CAPACITY];
  logic [CNT_W-1:0]     enq_upto, deq_upto;

  // evaluation logic
  logic                 enq_found, deq_found, enq_full, deq_full;
  logic [CNT_W-1:0]     enq_after, deq_after;
  logic [CNT_W-1:0]     size_diff;
  logic [SZ_W-1:0]      size_wide;
  logic [WANT_W-1:0]    want;
  logic                 query_ok;
  logic [STATUS_W-1:0]  status_eval;
  logic [SIZE_W-1:0]    size_eval;
  logic [VALUE_W-1:0]   sel_value;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) || ((state == S_SEL) && out_free);
  assign s_xfer   = s_tvalid && s_tready;

  assign time_wide = 64'(s_tdata[TIME_REQ_W-1:0]);

  // ---------------------------------------------------------------------
  // command capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      cmd_q  <= s_tuser;
      key_q  <= time_wide[TIME_BITS-1:0];
      val_q  <= s_tdata[TIME_REQ_W +: VALUE_W];
      rank_q <= s_tdata[TIME_REQ_W + VALUE_W +: RANK_W];
    end
  end

  // ---------------------------------------------------------------------
  // sorted rows: enqueue (time and value) and dequeue (time only)
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic                 enq_le_prev, enq_le_next, deq_le_prev, deq_le_next;
    logic [TIME_BITS-1:0] enq_prev_s, enq_next_s, deq_prev_s, deq_next_s;
    logic [VALUE_W-1:0]   enq_prev_v, enq_next_v;
    logic [0:0]           deq_prev_v, deq_next_v;

    assign enq_valid[i] = CNT_W'(i) < enq_cnt;
    assign deq_valid[i] = CNT_W'(i) < deq_cnt;

    if (i == 0) begin : g_first
      assign enq_le_prev = 1'b1;
      assign deq_le_prev = 1'b1;
      assign enq_prev_s  = '0;
      assign enq_prev_v  = '0;
      assign deq_prev_s  = '0;
      assign deq_prev_v  = '0;
    end else begin : g_mid_prev
      assign enq_le_prev = enq_le[i-1];
      assign deq_le_prev = deq_le[i-1];
      assign enq_prev_s  = enq_stamp[i-1];
      assign enq_prev_v  = enq_val[i-1];
      assign deq_prev_s  = deq_stamp[i-1];
      assign deq_prev_v  = deq_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign enq_le_next = 1'b0;
      assign deq_le_next = 1'b0;
      assign enq_next_s  = '0;
      assign enq_next_v  = '0;
      assign deq_next_s  = '0;
      assign deq_next_v  = '0;
    end else begin : g_mid_next
      assign enq_le_next = enq_le[i+1];
      assign deq_le_next = deq_le[i+1];
      assign enq_next_s  = enq_stamp[i+1];
      assign enq_next_v  = enq_val[i+1];
      assign deq_next_s  = deq_stamp[i+1];
      assign deq_next_v  = deq_val[i+1];
    end

    rqk_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS),
      .VAL_BITS  (VALUE_W),
      .WANT_W    (WANT_W)
    ) u_enq_cell (
      .clk        (clk),
      .ctl        (enq_ctl),
      .valid      (enq_valid[i]),
      .key        (key_q),
      .new_val    (val_q),
      .le_prev    (enq_le_prev),
      .le_next    (enq_le_next),
      .prev_stamp (enq_prev_s),
      .prev_val   (enq_prev_v),
      .next_stamp (enq_next_s),
      .next_val   (enq_next_v),
      .want       (st_want),
      .le         (enq_le[i]),
      .exact      (enq_exact[i]),
      .stamp      (enq_stamp[i]),
      .val        (enq_val[i]),
      .sel_val    (enq_sel[i])
    );

    // dequeue cells carry a one-bit dummy payload held at zero
    rqk_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS),
      .VAL_BITS  (1),
      .WANT_W    (WANT_W)
    ) u_deq_cell (
      .clk        (clk),
      .ctl        (deq_ctl),
      .valid      (deq_valid[i]),
      .key        (key_q),
      .new_val    (1'b0),
      .le_prev    (deq_le_prev),
      .le_next    (deq_le_next),
      .prev_stamp (deq_prev_s),
      .prev_val   (deq_prev_v),
      .next_stamp (deq_next_s),
      .next_val   (deq_next_v),
      .want       ('0),
      .le         (deq_le[i]),
      .exact      (deq_exact[i]),
      .stamp      (deq_stamp[i]),
      .val        (deq_val[i]),
      .sel_val    ()
    );
  end

  rqk_count #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_enq_count (
    .le    (enq_le),
    .count (enq_upto)
  );

  rqk_count #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_deq_count (
    .le    (deq_le),
    .count (deq_upto)
  );

  // ---------------------------------------------------------------------
  // evaluation step: row updates, counts after the change, status
  // ---------------------------------------------------------------------
  assign enq_found = |enq_exact;
  assign deq_found = |deq_exact;
  assign enq_full  = enq_cnt == CNT_W'(CAPACITY);
  assign deq_full  = deq_cnt == CNT_W'(CAPACITY);

  always_comb begin
    enq_ctl.ins = (state == S_EVAL) && (cmd_q == CMD_ADD_ENQ) && !enq_full;
    enq_ctl.rem = (state == S_EVAL) && (cmd_q == CMD_REM_ENQ) && enq_found;
    deq_ctl.ins = (state == S_EVAL) && (cmd_q == CMD_ADD_DEQ) && !deq_full;
    deq_ctl.rem = (state == S_EVAL) && (cmd_q == CMD_REM_DEQ) && deq_found;
  end

  // the new or removed entry sits exactly at the key, so it moves the count
  always_comb begin
    enq_after = enq_upto;
    deq_after = deq_upto;
    if (enq_ctl.ins) begin
      enq_after = enq_upto + CNT_W'(1);
    end else if (enq_ctl.rem) begin
      enq_after = enq_upto - CNT_W'(1);
    end
    if (deq_ctl.ins) begin
      deq_after = deq_upto + CNT_W'(1);
    end else if (deq_ctl.rem) begin
      deq_after = deq_upto - CNT_W'(1);
    end
  end

  assign enq_cnt_next = enq_ctl.ins ? enq_cnt + CNT_W'(1) :
                        enq_ctl.rem ? enq_cnt - CNT_W'(1) : enq_cnt;
  assign deq_cnt_next = deq_ctl.ins ? deq_cnt + CNT_W'(1) :
                        deq_ctl.rem ? deq_cnt - CNT_W'(1) : deq_cnt;

  // live size floored at zero and saturated to the field
  assign size_diff = (enq_after > deq_after) ? enq_after - deq_after : '0;
  assign size_wide = SZ_W'(size_diff);
  assign size_eval = (size_wide > SZ_W'(SIZE_MAX)) ? SIZE_MAX : size_wide[SIZE_W-1:0];

  // rank of the wanted enqueue: dequeues so far plus k
  assign want     = WANT_W'(deq_upto) + WANT_W'(rank_q);
  assign query_ok = (rank_q != '0) && (want <= WANT_W'(enq_upto));

  always_comb begin
    case (cmd_q)
      CMD_ADD_ENQ: status_eval = enq_full ? ST_FULL : ST_OK;
      CMD_ADD_DEQ: status_eval = deq_full ? ST_FULL : ST_OK;
      CMD_REM_ENQ: status_eval = enq_found ? ST_OK : ST_NOT_PRESENT;
      CMD_REM_DEQ: status_eval = deq_found ? ST_OK : ST_NOT_PRESENT;
      CMD_QUERY:   status_eval = query_ok ? ST_OK : ST_NO_ELEMENT;
      default:     status_eval = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      st_status <= status_eval;
      st_size   <= size_eval;
      st_want   <= want;
      st_qok    <= (cmd_q == CMD_QUERY) && query_ok;
    end
  end

  // ---------------------------------------------------------------------
  // select step: the one cell whose rank matches drives the value bus
  // ---------------------------------------------------------------------
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_value = sel_value | enq_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SEL) && out_free) begin
      out_status <= st_status;
      out_value  <= st_qok ? sel_value : '0;
      out_size   <= st_size;
    end
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_xfer) begin
        state_next = S_EVAL;
      end
      S_EVAL:  state_next = S_SEL;
      S_SEL:   if (out_free) begin
        state_next = s_xfer ? S_EVAL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      enq_cnt  <= '0;
      deq_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      enq_cnt <= enq_cnt_next;
      deq_cnt <= deq_cnt_next;
      if ((state == S_SEL) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(OUT_DATA_W - VALUE_W - SIZE_W){1'b0}}, out_size, out_value};

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // fill counts move only in the evaluation step
  a_cnt_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_EVAL) |=> ($stable(enq_cnt) && $stable(deq_cnt)))
    else $error("fill count changed outside evaluation");

  // a command taken in the select step never overruns a stalled result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_tready && (state == S_SEL)) |-> out_free)
    else $error("command accepted while result stalled");

  // a result appears only after a select step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_SEL))
    else $error("result without select step");

  // counts never exceed the row length
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (enq_cnt <= CNT_W'(CAPACITY)) && (deq_cnt <= CNT_W'(CAPACITY)))
    else $error("fill count beyond capacity");

endmodule

/* test/retroactive_queue_kth_query_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retroactive_queue_kth_query_check
// watches both stream channels, predicts each result and compares it
// ----------------------------------------------------------------------------
module retroactive_queue_kth_query_check #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rqk_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [rqk_pkg::CMD_W-1:0]      s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rqk_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [rqk_pkg::STATUS_W-1:0]   m_tuser,
  output int                             fail_count,
  output int                             results_due
);
  import rqk_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [SIZE_W-1:0]   size;
  } queue_result_t;

  // shadow of the two sorted tables
  logic [TIME_REQ_W-1:0] enq_time_q[$];
  logic [VALUE_W-1:0]    enq_value_q[$];
  logic [TIME_REQ_W-1:0] deq_time_q[$];
  queue_result_t         results_expected[$];
  int                    mismatches = 0;

  function automatic int enq_upto(input logic [TIME_REQ_W-1:0] t);
    int c = 0;
    foreach (enq_time_q[i]) if (enq_time_q[i] <= t) c++;
    return c;
  endfunction

  function automatic int deq_upto(input logic [TIME_REQ_W-1:0] t);
    int c = 0;
    foreach (deq_time_q[i]) if (deq_time_q[i] <= t) c++;
    return c;
  endfunction

  // applies one command to the shadow tables and returns its result
  function automatic queue_result_t apply_queue_op(input logic [CMD_W-1:0] cmd,
                                                   input logic [TIME_REQ_W-1:0] t,
                                                   input logic [VALUE_W-1:0] v,
                                                   input logic [RANK_W-1:0] k);
    queue_result_t r;
    int pos;
    int e;
    int d;
    int want;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ADD_ENQ: begin
        if (enq_time_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal times: new entry goes behind the older ones
          pos = enq_upto(t);
          enq_time_q.insert(pos, t);
          enq_value_q.insert(pos, v);
        end
      end
      CMD_ADD_DEQ: begin
        if (deq_time_q.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = deq_upto(t);
          deq_time_q.insert(pos, t);
        end
      end
      CMD_REM_ENQ: begin
        pos = enq_upto(t);
        if (pos == 0 || enq_time_q[pos-1] != t) begin
          r.status = ST_NOT_PRESENT;
        end else begin
          enq_time_q.delete(pos - 1);
          enq_value_q.delete(pos - 1);
        end
      end
      CMD_REM_DEQ: begin
        pos = deq_upto(t);
        if (pos == 0 || deq_time_q[pos-1] != t) begin
          r.status = ST_NOT_PRESENT;
        end else begin
          deq_time_q.delete(pos - 1);
        end
      end
      CMD_QUERY: begin
        e = enq_upto(t);
        d = deq_upto(t);
        want = d + int'(k);
        if (k == 0 || want > e || want > CAPACITY) begin
          r.status = ST_NO_ELEMENT;
        end else begin
          r.value = enq_value_q[want-1];
        end
      end
      default: begin
      end
    endcase
    e = enq_upto(t);
    d = deq_upto(t);
    if (e <= d) r.size = '0;
    else if (e - d > int'(SIZE_MAX)) r.size = SIZE_MAX;
    else r.size = SIZE_W'(e - d);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    queue_result_t got;
    queue_result_t pred;
    if (rst) begin
      enq_time_q.delete();
      enq_value_q.delete();
      deq_time_q.delete();
      results_expected.delete();
    end else begin
      // results leave only after their command is taken, so compare first
      if (m_tvalid && m_tready) begin
        if (results_expected.size() == 0) begin
          $error("result transaction with nothing expected: status %0d value %0d size %0d",
                 m_tuser, m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: SIZE_W]);
          mismatches++;
        end else begin
          got = results_expected.pop_front();
          if (m_tuser !== got.status) begin
            $error("status: expected %0d, actual %0d", got.status, m_tuser);
            mismatches++;
          end
          if (m_tdata[VALUE_W-1:0] !== got.value) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(got.value), $signed(m_tdata[VALUE_W-1:0]));
            mismatches++;
          end
          if (m_tdata[VALUE_W +: SIZE_W] !== got.size) begin
            $error("live_size: expected %0d, actual %0d",
                   got.size, m_tdata[VALUE_W +: SIZE_W]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pred = apply_queue_op(s_tuser,
                              s_tdata[TIME_REQ_W-1:0],
                              s_tdata[TIME_REQ_W +: VALUE_W],
                              s_tdata[TIME_REQ_W+VALUE_W +: RANK_W]);
        results_expected.insert(results_expected.size(), pred);
      end
    end
    fail_count <= mismatches;
    results_due <= results_expected.size();
  end

endmodule

/* test/retroactive_queue_kth_query_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retroactive_queue_kth_query_test
// stimulus and verdict for the retroactive queue with k-th element query
// ----------------------------------------------------------------------------
// a directed opening hits the empty tables, equal timestamps, the time and
// value extremes, rank zero and far ranks, missing removes and the unknown
// command codes. random rounds then fill both tables to full, churn them and
// drain them again over a small pool of timestamps so that removes and
// queries mostly land on live entries. both sides idle at random, with some
// rounds running back to back. a separate checker predicts every result.
// ----------------------------------------------------------------------------
module retroactive_queue_kth_query_test;
  import rqk_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int ROUNDS      = 12;
  localparam int ROUND_ITEMS = 128;
  // cycles without any transaction before the run is called hung
  localparam int STALL_LIMIT = 2000;

  // mix of commands in a random round
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  int   fail_count;
  int   results_due;
  bit   steady       = 1'b0;  // no idling on either side while set
  bit   result_taken = 1'b0;
  int   ready_hold   = 0;
  int   idle_cycles  = 0;

  always #5 clk = ~clk;

  retroactive_queue_kth_query #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  retroactive_queue_kth_query_check #(
    .CAPACITY (CAPACITY)
  ) checker_inst (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // result side: a fresh stall is drawn after every result transaction
  always @(posedge clk) result_taken <= !rst && m_tvalid && m_tready;

  always @(negedge clk) begin
    if (result_taken) ready_hold = steady ? 0 : $urandom_range(0, 7);
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // hang detection: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("retroactive_queue_kth_query_test failed");
        $finish;
      end
    end
  end

  // one command transaction; called and returns at a falling edge
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_REQ_W-1:0] t,
                          input logic [VALUE_W-1:0] v, input logic [RANK_W-1:0] k);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_W'({k, v, t});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the command side until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0] cmd_order[5];
    int               mix_limit[3][5];
    mix_t             mix;
    int               roll;
    int               sel;
    logic [CMD_W-1:0] cmd;
    logic [TIME_REQ_W-1:0] t;
    logic [RANK_W-1:0]     k;

    cmd_order = '{CMD_ADD_ENQ, CMD_ADD_DEQ, CMD_REM_ENQ, CMD_REM_DEQ, CMD_QUERY};
    // cumulative percent thresholds per command, the rest are unknown codes
    mix_limit = '{'{35, 70, 75, 80, 97},
                  '{20, 40, 55, 70, 97},
                  '{5, 10, 45, 80, 97}};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty tables: query and both removes find nothing
    send_cmd(CMD_QUERY,   32'd0, 32'd0, 7'd1);
    send_cmd(CMD_REM_ENQ, 32'd5, 32'd0, 7'd1);
    send_cmd(CMD_REM_DEQ, 32'd5, 32'd0, 7'd1);
    // two enqueues with equal time keep their insertion order
    send_cmd(CMD_ADD_ENQ, 32'd0, 32'h7fff_ffff, 7'd0);
    send_cmd(CMD_ADD_ENQ, 32'd0, 32'h8000_0000, 7'd0);
    send_cmd(CMD_ADD_ENQ, 32'hffff_ffff, 32'hffff_ffff, 7'd0);
    send_cmd(CMD_ADD_DEQ, 32'd0, 32'd0, 7'd0);
    // one dequeue at time zero, so the front is the second enqueue
    send_cmd(CMD_QUERY,   32'd0, 32'd0, 7'd1);
    send_cmd(CMD_QUERY,   32'd0, 32'd0, 7'd0);
    send_cmd(CMD_QUERY,   32'hffff_ffff, 32'd0, 7'd127);
    send_cmd(CMD_QUERY,   32'hffff_ffff, 32'd0, 7'd2);
    // remove takes the latest inserted of the equal times
    send_cmd(CMD_REM_ENQ, 32'd0, 32'd0, 7'd0);
    send_cmd(CMD_QUERY,   32'd0, 32'd0, 7'd1);
    // more dequeues than enqueues: size floors at zero
    send_cmd(CMD_ADD_DEQ, 32'd3, 32'd0, 7'd0);
    send_cmd(CMD_ADD_DEQ, 32'd7, 32'd0, 7'd0);
    send_cmd(CMD_QUERY,   32'd7, 32'd0, 7'd1);
    // exact match removes, a time between entries does not
    send_cmd(CMD_REM_DEQ, 32'd3, 32'd0, 7'd0);
    send_cmd(CMD_REM_DEQ, 32'd4, 32'd0, 7'd0);
    // unknown command codes only report the size
    for (int c = int'(CMD_QUERY) + 1; c < (1 << CMD_W); c++) begin
      send_cmd(CMD_W'(c), 32'hffff_ffff, $urandom, 7'($urandom));
    end
    wait_drained();

    // fill, fill, churn, drain; churn rounds run without idling
    for (int round = 0; round < ROUNDS; round++) begin
      case (round % 4)
        0, 1: mix = MIX_FILL;
        2: mix = MIX_CHURN;
        default: mix = MIX_DRAIN;
      endcase
      steady = (round % 4 == 2);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        sel = 5;
        for (int i = 4; i >= 0; i--) if (roll < mix_limit[mix][i]) sel = i;
        if (sel < 5) cmd = cmd_order[sel];
        else cmd = CMD_W'($urandom_range(int'(CMD_QUERY) + 1, (1 << CMD_W) - 1));
        // small time pool so that removes and queries hit live entries
        roll = $urandom_range(0, 31);
        if (roll == 0) t = '1;
        else if (roll < 3) t = $urandom;
        else t = TIME_REQ_W'($urandom_range(0, 31));
        if ($urandom_range(0, 7) == 0) k = RANK_W'($urandom);
        else k = RANK_W'($urandom_range(1, 6));
        send_cmd(cmd, t, $urandom, k);
      end
      steady = 1'b0;
      if (round == ROUNDS / 2) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("retroactive_queue_kth_query_test passed");
    end else begin
      $display("retroactive_queue_kth_query_test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rqk_pkg.sv
rtl/rqk_cell.sv
rtl/rqk_count.sv
rtl/retroactive_queue_kth_query.sv
test/retroactive_queue_kth_query_check.sv
test/retroactive_queue_kth_query_test.sv
